// ===== src/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; imported by every module of the block.
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int CFG_W          = 31;
   localparam int CSR_INDEX_W    = 1;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRACE_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_FLOOR      = 1'd1;

   localparam logic [CFG_W-1:0] TRACE_THRESHOLD_RST = 31'd10737;
   localparam logic [CFG_W-1:0] NORM_FLOOR_RST      = 31'd11;

   // quaternion component positions
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;
   localparam logic [1:0] COMP_W = 2'd3;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT1,
      ST_LOAD1,
      ST_DIV1,
      ST_SQUARE,
      ST_ROOT2,
      ST_LOAD2,
      ST_DIV2,
      ST_WRITE
   } back_state_type;

   // queue word: {branch, dominant component, radicand, num3, num2, num1, num0}
   function automatic int entry_width(input int w);
      return 4 + 5 * (w + 1);
   endfunction

endpackage

// ===== src/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion (Shepperd's method) in Q2.30 fixed point.
// A front end classifies each matrix word (trace or dominant-diagonal branch)
// and hands it through a two-word queue to a back end that runs one bit-serial
// square root, four divider lanes in parallel, a squaring accumulator, a
// second root for the magnitude and a second divider pass; the result sits in
// an output register, so a finished word can wait while the next one is taken.
// A word occupies the back end through two DATA_WIDTH-step roots and two
// DATA_WIDTH-1-step divider passes; a word whose magnitude falls at or below
// norm_floor skips the second pass. Registers: index 0 trace_threshold,
// index 1 norm_floor.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_m00,
   input  logic signed [DATA_WIDTH-1:0] req_m01,
   input  logic signed [DATA_WIDTH-1:0] req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10,
   input  logic signed [DATA_WIDTH-1:0] req_m11,
   input  logic signed [DATA_WIDTH-1:0] req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20,
   input  logic signed [DATA_WIDTH-1:0] req_m21,
   input  logic signed [DATA_WIDTH-1:0] req_m22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_qx,
   output logic signed [DATA_WIDTH-1:0] rsp_qy,
   output logic signed [DATA_WIDTH-1:0] rsp_qz,
   output logic signed [DATA_WIDTH-1:0] rsp_qw,
   output logic                         rsp_fell_back,
   output logic [1:0]                   rsp_branch_taken,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]             csr_wdata
);

   localparam int EW = entry_width(DATA_WIDTH);

   logic [CFG_W-1:0] trace_threshold_ff, norm_floor_ff;
   logic [EW-1:0]    front_word, back_word;
   logic             q_full, q_push, q_pop, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_threshold_ff <= TRACE_THRESHOLD_RST;
         norm_floor_ff      <= NORM_FLOOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRACE_THRESHOLD: trace_threshold_ff <= csr_wdata;
            CSR_NORM_FLOOR:      norm_floor_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   rmq_front #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_front (
      .m00(req_m00),
      .m01(req_m01),
      .m02(req_m02),
      .m10(req_m10),
      .m11(req_m11),
      .m12(req_m12),
      .m20(req_m20),
      .m21(req_m21),
      .m22(req_m22),
      .trace_threshold(trace_threshold_ff),
      .entry(front_word)
   );

   rmq_queue #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(front_word),
      .full(q_full),
      .pop(q_pop),
      .pop_data(back_word),
      .not_empty(q_valid)
   );

   rmq_back #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_entry(back_word),
      .q_pop(q_pop),
      .norm_floor(norm_floor_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_qx(rsp_qx),
      .rsp_qy(rsp_qy),
      .rsp_qz(rsp_qz),
      .rsp_qw(rsp_qw),
      .rsp_fell_back(rsp_fell_back),
      .rsp_branch_taken(rsp_branch_taken)
   );

endmodule

// ===== src/rmq_front.sv =====
// Front end: picks the branch, forms the radicand and the four numerators.
// Depends on rmq_pkg.
module rmq_front
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic signed [DATA_WIDTH-1:0]          m00,
   input  logic signed [DATA_WIDTH-1:0]          m01,
   input  logic signed [DATA_WIDTH-1:0]          m02,
   input  logic signed [DATA_WIDTH-1:0]          m10,
   input  logic signed [DATA_WIDTH-1:0]          m11,
   input  logic signed [DATA_WIDTH-1:0]          m12,
   input  logic signed [DATA_WIDTH-1:0]          m20,
   input  logic signed [DATA_WIDTH-1:0]          m21,
   input  logic signed [DATA_WIDTH-1:0]          m22,
   input  logic [CFG_W-1:0]                      trace_threshold,
   output logic [entry_width(DATA_WIDTH)-1:0]    entry
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = W - 2;
   localparam int AW = W + 2;
   localparam int NW = W + 1;
   localparam int RW = W + 1;
   localparam int XW = (AW > CFG_W + 1) ? AW : CFG_W + 1;
   localparam logic signed [AW-1:0] ONE = AW'(1) <<< F;

   logic signed [AW-1:0] e00, e11, e22;
   logic signed [AW-1:0] opt, rad_x, rad_y, rad_z, rad_s;
   logic signed [XW-1:0] opt_x, thr_x;
   logic signed [NW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
   logic signed [NW-1:0] num [4];
   logic [RW-1:0]        rad;
   logic [1:0]           dom;
   branch_type           br;

   assign e00 = AW'(m00);
   assign e11 = AW'(m11);
   assign e22 = AW'(m22);

   assign opt   = ONE + e00 + e11 + e22;
   assign rad_x = ONE + e00 - e11 - e22;
   assign rad_y = ONE + e11 - e00 - e22;
   assign rad_z = ONE + e22 - e00 - e11;
   assign opt_x = XW'(opt);
   assign thr_x = XW'(trace_threshold);

   assign d21_12 = NW'(m21) - NW'(m12);
   assign d02_20 = NW'(m02) - NW'(m20);
   assign d10_01 = NW'(m10) - NW'(m01);
   assign s01_10 = NW'(m01) + NW'(m10);
   assign s02_20 = NW'(m02) + NW'(m20);
   assign s12_21 = NW'(m12) + NW'(m21);

   always_comb begin
      priority if (opt_x > thr_x) begin
         br = BR_TRACE;
      end else if (m00 > m11 && m00 > m22) begin
         br = BR_X;
      end else if (m11 > m22) begin
         br = BR_Y;
      end else begin
         br = BR_Z;
      end
   end

   always_comb begin
      num[0] = '0;
      num[1] = '0;
      num[2] = '0;
      num[3] = '0;
      unique case (br)
         BR_TRACE: begin
            rad_s  = opt;
            dom    = COMP_W;
            num[0] = d21_12;
            num[1] = d02_20;
            num[2] = d10_01;
         end
         BR_X: begin
            rad_s  = rad_x;
            dom    = COMP_X;
            num[1] = s01_10;
            num[2] = s02_20;
            num[3] = d21_12;
         end
         BR_Y: begin
            rad_s  = rad_y;
            dom    = COMP_Y;
            num[0] = s01_10;
            num[2] = s12_21;
            num[3] = d02_20;
         end
         default: begin
            rad_s  = rad_z;
            dom    = COMP_Z;
            num[0] = s02_20;
            num[1] = s12_21;
            num[3] = d10_01;
         end
      endcase
   end

   // drop a negative radicand to zero
   assign rad = rad_s[AW-1] ? '0 : rad_s[RW-1:0];

   assign entry = {br, dom, rad, num[3], num[2], num[1], num[0]};

endmodule

// ===== src/rmq_queue.sv =====
// Small word queue between the front end and the back end.
// Depends on rmq_pkg.
module rmq_queue
   import rmq_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue read while empty");

endmodule

// ===== src/rmq_back.sv =====
// Back end: shared square root unit, four divider lanes and a squaring
// accumulator under one sequencer; holds the result register. Depends on rmq_pkg.
module rmq_back
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  logic [entry_width(DATA_WIDTH)-1:0] q_entry,
   output logic                               q_pop,
   input  logic [CFG_W-1:0]                   norm_floor,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [DATA_WIDTH-1:0]       rsp_qx,
   output logic signed [DATA_WIDTH-1:0]       rsp_qy,
   output logic signed [DATA_WIDTH-1:0]       rsp_qz,
   output logic signed [DATA_WIDTH-1:0]       rsp_qw,
   output logic                               rsp_fell_back,
   output logic [1:0]                         rsp_branch_taken
);

   localparam int W   = DATA_WIDTH;
   localparam int F   = W - 2;
   localparam int NW  = W + 1;
   localparam int RW  = W + 1;
   localparam int DW  = 2 * W - 2;
   localparam int SCW = $clog2(W);
   localparam int DCW = $clog2(W - 1);
   localparam int FW  = (W > CFG_W) ? W : CFG_W;
   localparam logic [SCW-1:0] SR_LAST = SCW'(W - 1);
   localparam logic [DCW-1:0] DV_LAST = DCW'(W - 2);
   localparam logic [2:0]     SQ_LAST = 3'd4;
   localparam logic [W-2:0]   QMAX    = '1;
   localparam logic [W-1:0]   ONE     = W'(1) << F;
   localparam logic [W-1:0]   MINV    = W'(1) << (W - 1);

   back_state_type state_ff, state_in;

   // controls
   logic sr_start, sr_step, sr_from_sum, ld_lanes, phase2, dv_step;
   logic sq_step, sq_save, fell_load, out_load, out_free, fell_now;

   // queue word
   logic signed [NW-1:0] e_num [4];
   logic [RW-1:0]        e_rad;
   logic [1:0]           e_dom;
   logic [1:0]           e_br;

   // item
   logic signed [NW-1:0] it_num_ff [4];
   logic [1:0]           it_dom_ff;
   logic [1:0]           it_br_ff;
   logic                 fell_ff;

   // square root
   logic [2*W-1:0] sr_x_ff, sr_src;
   logic [W-1:0]   sr_rem_ff, sr_root_ff;
   logic [SCW-1:0] sr_cnt_ff;
   logic [W+1:0]   sr_rem2, sr_trial, sr_sub;
   logic           sr_ge;

   // divider lanes
   logic [W-1:0]   ln_rem_ff [4];
   logic [W-2:0]   ln_low_ff [4];
   logic [W-2:0]   ln_quo_ff [4];
   logic [3:0]     ln_sat_ff, ln_zero_ff;
   logic [DCW-1:0] dv_cnt_ff;
   logic [NW-1:0]  num_mag [4];
   logic [DW-1:0]  ld_d [4];
   logic [3:0]     ld_zero, ld_sat, ln_ge;
   logic [W:0]     ln_rem2 [4];
   logic [W:0]     ln_sub [4];
   logic [W-2:0]   ln_mag [4];

   // raw components and squares
   logic [W-2:0]   c_mag [4];
   logic [3:0]     c_neg;
   logic [W-2:0]   qm_ff [4];
   logic [3:0]     qn_ff;
   logic [2:0]     sq_cnt_ff;
   logic [W-2:0]   sq_in;
   logic [2*W-3:0] sq_prod, prod_ff;
   logic [2*W-1:0] acc_ff;

   // result
   logic           rsp_valid_ff;
   logic [W-1:0]   o_val [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         e_num[i] = q_entry[i*NW +: NW];
      end
   end
   assign e_rad = q_entry[4*NW +: RW];
   assign e_dom = q_entry[4*NW+RW +: 2];
   assign e_br  = q_entry[4*NW+RW+2 +: 2];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fell_now = FW'(sr_root_ff) <= FW'(norm_floor);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_ROOT1;
         ST_ROOT1:  if (sr_cnt_ff == SR_LAST) state_in = ST_LOAD1;
         ST_LOAD1:  state_in = ST_DIV1;
         ST_DIV1:   if (dv_cnt_ff == DV_LAST) state_in = ST_SQUARE;
         ST_SQUARE: if (sq_cnt_ff == SQ_LAST) state_in = ST_ROOT2;
         ST_ROOT2:  if (sr_cnt_ff == SR_LAST) state_in = ST_LOAD2;
         ST_LOAD2:  state_in = fell_now ? ST_WRITE : ST_DIV2;
         ST_DIV2:   if (dv_cnt_ff == DV_LAST) state_in = ST_WRITE;
         ST_WRITE:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      sr_start    = 1'b0;
      sr_step     = 1'b0;
      sr_from_sum = 1'b0;
      ld_lanes    = 1'b0;
      phase2      = 1'b0;
      dv_step     = 1'b0;
      sq_step     = 1'b0;
      sq_save     = 1'b0;
      fell_load   = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop    = q_valid;
            sr_start = q_valid;
         end
         ST_ROOT1, ST_ROOT2: sr_step = 1'b1;
         ST_LOAD1: ld_lanes = 1'b1;
         ST_DIV1, ST_DIV2: dv_step = 1'b1;
         ST_SQUARE: begin
            sq_step     = 1'b1;
            sq_save     = (sq_cnt_ff == '0);
            sr_start    = (sq_cnt_ff == SQ_LAST);
            sr_from_sum = 1'b1;
         end
         ST_LOAD2: begin
            phase2    = 1'b1;
            ld_lanes  = !fell_now;
            fell_load = 1'b1;
         end
         ST_WRITE: out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sr_cnt_ff    <= '0;
         dv_cnt_ff    <= '0;
         sq_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (sr_start) begin
            sr_cnt_ff <= '0;
         end else if (sr_step) begin
            sr_cnt_ff <= sr_cnt_ff + SCW'(1);
         end
         if (ld_lanes) begin
            dv_cnt_ff <= '0;
         end else if (dv_step) begin
            dv_cnt_ff <= dv_cnt_ff + DCW'(1);
         end
         sq_cnt_ff <= sq_step ? sq_cnt_ff + 3'd1 : 3'd0;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- square root, one result bit per radicand pair ----------------
   assign sr_src   = sr_from_sum ? acc_ff + (2*W)'(prod_ff) : {1'b0, e_rad, {F{1'b0}}};
   assign sr_rem2  = {sr_rem_ff, sr_x_ff[2*W-1 -: 2]};
   assign sr_trial = {sr_root_ff, 2'b01};
   assign sr_ge    = sr_rem2 >= sr_trial;
   assign sr_sub   = sr_rem2 - sr_trial;

   always_ff @(posedge clock) begin
      if (sr_start) begin
         sr_x_ff    <= sr_src;
         sr_rem_ff  <= '0;
         sr_root_ff <= '0;
      end else if (sr_step) begin
         sr_x_ff    <= sr_x_ff << 2;
         sr_rem_ff  <= sr_ge ? sr_sub[W-1:0] : sr_rem2[W-1:0];
         sr_root_ff <= {sr_root_ff[W-2:0], sr_ge};
      end
   end

   // ---------------- divider lanes, divisor is the current root ----------------
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num_mag[i] = it_num_ff[i][NW-1] ? NW'(-it_num_ff[i]) : NW'(it_num_ff[i]);
         if (phase2) begin
            ld_d[i]    = {1'b0, qm_ff[i], {F{1'b0}}};
            ld_zero[i] = (qm_ff[i] == '0);
         end else begin
            ld_d[i]    = {num_mag[i], {(F-1){1'b0}}};
            ld_zero[i] = (num_mag[i] == '0);
         end
         // quotient would not fit: saturate
         ld_sat[i]  = {1'b0, ld_d[i]} >= {sr_root_ff, {(W-1){1'b0}}};
         ln_rem2[i] = {ln_rem_ff[i], ln_low_ff[i][W-2]};
         ln_ge[i]   = ln_rem2[i] >= {1'b0, sr_root_ff};
         ln_sub[i]  = ln_rem2[i] - {1'b0, sr_root_ff};
         ln_mag[i]  = ln_zero_ff[i] ? '0 : (ln_sat_ff[i] ? QMAX : ln_quo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (ld_lanes) begin
            ln_rem_ff[i]  <= {1'b0, ld_d[i][DW-1:W-1]};
            ln_low_ff[i]  <= ld_d[i][W-2:0];
            ln_quo_ff[i]  <= '0;
            ln_sat_ff[i]  <= ld_sat[i];
            ln_zero_ff[i] <= ld_zero[i];
         end else if (dv_step) begin
            ln_rem_ff[i] <= ln_ge[i] ? ln_sub[i][W-1:0] : ln_rem2[i][W-1:0];
            ln_low_ff[i] <= ln_low_ff[i] << 1;
            ln_quo_ff[i] <= {ln_quo_ff[i][W-3:0], ln_ge[i]};
         end
      end
   end

   // ---------------- raw components and sum of squares ----------------
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         c_mag[i] = (it_dom_ff == 2'(i)) ? sr_root_ff[W-1:1] : ln_mag[i];
         c_neg[i] = (it_dom_ff != 2'(i)) && it_num_ff[i][NW-1];
      end
   end

   assign sq_in   = c_mag[sq_cnt_ff[1:0]];
   assign sq_prod = (2*W-2)'(sq_in) * (2*W-2)'(sq_in);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < 4; i++) begin
            it_num_ff[i] <= e_num[i];
         end
         it_dom_ff <= e_dom;
         it_br_ff  <= e_br;
      end
      if (sq_save) begin
         for (int i = 0; i < 4; i++) begin
            qm_ff[i] <= c_mag[i];
         end
         qn_ff <= c_neg;
      end
      if (sq_step) begin
         prod_ff <= sq_prod;
         acc_ff  <= (sq_cnt_ff == '0) ? '0 : acc_ff + (2*W)'(prod_ff);
      end
      if (fell_load) begin
         fell_ff <= fell_now;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (fell_ff) begin
            o_val[i] = (i == 3) ? ONE : '0;
         end else begin
            o_val[i] = qn_ff[i] ? -{1'b0, ln_mag[i]} : {1'b0, ln_mag[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_qx           <= o_val[0];
         rsp_qy           <= o_val[1];
         rsp_qz           <= o_val[2];
         rsp_qw           <= o_val[3];
         rsp_fell_back    <= fell_ff;
         rsp_branch_taken <= it_br_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fell_back |->
         rsp_qw == ONE && rsp_qx == '0 && rsp_qy == '0 && rsp_qz == '0)
      else $error("fallback word is not the identity");

   a_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_qx != MINV && rsp_qy != MINV && rsp_qz != MINV && rsp_qw != MINV)
      else $error("component outside symmetric range");

   a_floor_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD2 && fell_now |=> state_ff == ST_WRITE && fell_ff)
      else $error("small magnitude did not take the identity path");

   a_pop_start: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_ROOT1 && sr_cnt_ff == '0)
      else $error("popped word did not start the root");

endmodule
